/* rtl/core/acs_pkg.sv */
// Shared types and constants for the accumulator cpu step block.
// Holds widths, command and opcode codes, the sequencer state and the memory request struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

    localparam int MEM_WORDS_DEF = 32;
    localparam int ADDR_W        = 5;
    localparam int WORD_W        = 8;
    localparam int OP_W          = 3;
    localparam int CMD_W         = 2;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd2;

    // instruction opcodes (upper three bits of a word)
    typedef enum logic [OP_W-1:0] {
        OP_STORE = 3'd0,
        OP_LOAD  = 3'd1,
        OP_BRZ   = 3'd2,
        OP_NOP   = 3'd3,
        OP_DEC   = 3'd4,
        OP_INC   = 3'd5,
        OP_JMP   = 3'd6,
        OP_HALT  = 3'd7
    } opcode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_DECODE  = 2'd1,
        ST_OPERAND = 2'd2,
        ST_RESP    = 2'd3
    } state_t;

    // access request to the program/data memory (write and read port)
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/acs_mem.sv */
// Program and data memory: one write port, one read port, registered read data.
// Depends on acs_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module acs_mem #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
    input  wire                            clk,
    input  acs_pkg::mem_req_t              req,
    output logic [acs_pkg::WORD_W-1:0]     rdata
);
    import acs_pkg::*;

    logic [WORD_W-1:0] mem_array [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem_array[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/acs_ctrl.sv */
// Sequencer and architectural registers: accepts requests, fetches and decodes
// instructions through the memory port, and fills the result register.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acs_ctrl (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cmd_valid,
    output logic                           cmd_stall,
    input  wire  [acs_pkg::CMD_W-1:0]      command,
    input  wire  [acs_pkg::ADDR_W-1:0]     address,
    input  wire  [acs_pkg::WORD_W-1:0]     word_data,
    output logic                           res_valid,
    input  wire                            res_stall,
    output logic [acs_pkg::WORD_W-1:0]     accumulator,
    output logic [acs_pkg::ADDR_W-1:0]     program_counter,
    output logic                           halted,
    output acs_pkg::mem_req_t              mem_req,
    input  wire  [acs_pkg::WORD_W-1:0]     mem_rdata
);
    import acs_pkg::*;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic              halt_reg, halt_next;

    logic              res_valid_reg, res_valid_next;
    logic [WORD_W-1:0] res_acc_reg, res_acc_next;
    logic [ADDR_W-1:0] res_pc_reg, res_pc_next;
    logic              res_halt_reg, res_halt_next;

    logic              out_free;
    logic              commit;
    opcode_t           opcode;
    logic [ADDR_W-1:0] operand;
    logic [ADDR_W-1:0] pc_inc;

    assign out_free = !res_valid_reg || !res_stall;
    assign opcode   = opcode_t'(mem_rdata[WORD_W-1 -: OP_W]);
    assign operand  = mem_rdata[ADDR_W-1:0];
    assign pc_inc   = pc_reg + ADDR_W'(1);

    assign cmd_stall = (state_reg != ST_IDLE);

    // next state, register updates and memory requests
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        commit     = 1'b0;
        mem_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (command)
                        CMD_LOAD:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = address;
                            mem_req.wdata = word_data;
                            state_next    = ST_RESP;
                        end
                        CMD_START:
                        begin
                            acc_next   = '0;
                            pc_next    = '0;
                            halt_next  = 1'b0;
                            state_next = ST_RESP;
                        end
                        CMD_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pc_reg;
                                state_next    = ST_DECODE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_DECODE:
            begin
                if (opcode == OP_LOAD)
                begin
                    // second read for the data word
                    mem_req.re    = 1'b1;
                    mem_req.raddr = operand;
                    state_next    = ST_OPERAND;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                    unique case (opcode)
                        OP_STORE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = operand;
                            mem_req.wdata = acc_reg;
                            pc_next       = pc_inc;
                        end
                        OP_BRZ:  pc_next = (acc_reg == '0) ? operand : pc_inc;
                        OP_DEC:
                        begin
                            acc_next = acc_reg - WORD_W'(1);
                            pc_next  = pc_inc;
                        end
                        OP_INC:
                        begin
                            acc_next = acc_reg + WORD_W'(1);
                            pc_next  = pc_inc;
                        end
                        OP_JMP:  pc_next = operand;
                        OP_HALT:
                        begin
                            pc_next   = pc_inc;
                            halt_next = 1'b1;
                        end
                        default: pc_next = pc_inc;
                    endcase
                end
            end
            ST_OPERAND:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    acc_next   = mem_rdata;
                    pc_next    = pc_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register: loads on commit, clears once taken
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_acc_next   = res_acc_reg;
        res_pc_next    = res_pc_reg;
        res_halt_next  = res_halt_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
            res_acc_next   = acc_next;
            res_pc_next    = pc_next;
            res_halt_next  = halt_next;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_acc_reg  <= res_acc_next;
        res_pc_reg   <= res_pc_next;
        res_halt_reg <= res_halt_next;
    end

    assign res_valid       = res_valid_reg;
    assign accumulator     = res_acc_reg;
    assign program_counter = res_pc_reg;
    assign halted          = res_halt_reg;

endmodule

`default_nettype wire

/* rtl/core/accumulator_cpu_step.sv */
// Accumulator cpu step: a small 8-bit accumulator machine with a 32-word memory
// that takes one request at a time (load a word, start, or execute one
// instruction) and returns the accumulator, program counter and halt flag after
// it. A load, start or halted execute passes through the response state; an
// executed instruction is fetched and decoded, and a load instruction then reads
// its data word through the single memory read port, whose read data is
// registered. A new request is taken in the cycle after a result is produced,
// even while that result still waits in the output register. Memory has no reset.
// Depends on acs_pkg, acs_ctrl and acs_mem.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_step #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cmd_valid,
    output logic                           cmd_stall,
    input  wire  [acs_pkg::CMD_W-1:0]      command,
    input  wire  [acs_pkg::ADDR_W-1:0]     address,
    input  wire  [acs_pkg::WORD_W-1:0]     word_data,
    output logic                           res_valid,
    input  wire                            res_stall,
    output logic [acs_pkg::WORD_W-1:0]     accumulator,
    output logic [acs_pkg::ADDR_W-1:0]     program_counter,
    output logic                           halted
);
    import acs_pkg::*;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rdata;

    // sequencer and registers
    acs_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command         (command),
        .address         (address),
        .word_data       (word_data),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .accumulator     (accumulator),
        .program_counter (program_counter),
        .halted          (halted),
        .mem_req         (mem_req),
        .mem_rdata       (mem_rdata)
    );

    // program and data memory
    acs_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    // memory is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request accepted while another is in flight");

    // a new result only comes from a request in flight
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result produced without a request");
`endif

endmodule

`default_nettype wire
